>>> hdl/rahfp_pkg.sv
// shared types, constants and codes of the rfid ascii hex frame parser
`default_nettype none

package rahfp_pkg;

   // frame layout: start code, twelve hex digits, end code
   localparam int FRAME_BYTES = 14;
   localparam int HEX_DIGITS  = FRAME_BYTES - 2;
   localparam int SHIFT_BITS  = 4 * HEX_DIGITS;
   localparam int POS_W       = $clog2(FRAME_BYTES + 1);

   localparam int QUEUE_DEPTH = 2;

   // configuration reset values
   localparam logic [15:0] TIMEOUT_RESET    = 16'd100;
   localparam logic [7:0]  START_CODE_RESET = 8'h02;
   localparam logic [7:0]  END_CODE_RESET   = 8'h03;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMEOUT    = 2'd0,
      CSR_START_CODE = 2'd1,
      CSR_END_CODE   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_TAG   = 2'd1,
      EV_ERROR = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_TIMEOUT     = 3'd1,
      ERR_BAD_END     = 3'd2,
      ERR_BAD_HEX     = 3'd3,
      ERR_BAD_CHECKSUM = 3'd4
   } error_type;

   // classified request, as queued between front and back
   typedef struct packed {
      logic        func;
      logic        is_start;
      logic        is_end;
      logic        hex_ok;
      logic [3:0]  nibble;
      logic [31:0] now_ms;
   } cls_type;

endpackage

`default_nettype wire

>>> hdl/rahfp_if.sv
// request and response channel interfaces
`default_nettype none

interface rahfp_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  data_byte;
   logic [31:0] now_ms;

   modport source (output valid, func, data_byte, now_ms, input ready);
   modport sink   (input valid, func, data_byte, now_ms, output ready);
endinterface

interface rahfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [2:0]  error_code;
   logic [7:0]  tag_version;
   logic [31:0] tag_id;
   logic [7:0]  tag_checksum;

   modport source (output valid, event_res, error_code, tag_version, tag_id, tag_checksum,
                   input ready);
   modport sink   (input valid, event_res, error_code, tag_version, tag_id, tag_checksum,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/rahfp_front.sv
// front: accepts requests and classifies each byte
`default_nettype none

module rahfp_front (
   rahfp_req_if.sink          req_chan,
   input  wire logic [7:0]    start_code,
   input  wire logic [7:0]    end_code,
   input  wire logic          q_full,
   output logic               q_push,
   output rahfp_pkg::cls_type q_item
);

   localparam logic [7:0] CHAR_0  = 8'h30;
   localparam logic [7:0] CHAR_9  = 8'h39;
   localparam logic [7:0] CHAR_UA = 8'h41;
   localparam logic [7:0] CHAR_UF = 8'h46;
   localparam logic [7:0] CHAR_LA = 8'h61;
   localparam logic [7:0] CHAR_LF = 8'h66;

   // {valid, value} of one ascii hex digit, either case
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      logic [4:0] r;
      d = 8'd0;
      r = 5'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = c - CHAR_0;
         r = {1'b1, d[3:0]};
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = c - CHAR_UA;
         r = {1'b1, d[3:0] + 4'd10};
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         d = c - CHAR_LA;
         r = {1'b1, d[3:0] + 4'd10};
      end
      return r;
   endfunction

   logic [4:0] hex;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;
   assign hex            = hex_nibble(req_chan.data_byte);

   always_comb begin
      q_item.func     = req_chan.func;
      q_item.is_start = (req_chan.data_byte == start_code);
      q_item.is_end   = (req_chan.data_byte == end_code);
      q_item.hex_ok   = hex[4];
      q_item.nibble   = hex[3:0];
      q_item.now_ms   = req_chan.now_ms;
   end

endmodule

`default_nettype wire

>>> hdl/rahfp_queue.sv
// short fifo of classified requests between front and back
`default_nettype none

module rahfp_queue #(
   parameter int DEPTH = rahfp_pkg::QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire rahfp_pkg::cls_type        push_item,
   input  wire logic                      pop,
   output logic                           full,
   output logic                           head_valid,
   output rahfp_pkg::cls_type             head_item,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rahfp_pkg::cls_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> hdl/rahfp_back.sv
// back: frame assembly, timeout, checks and the response register
`default_nettype none

module rahfp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [15:0]        timeout_ms,
   input  wire logic               q_valid,
   input  wire rahfp_pkg::cls_type q_item,
   output logic                    q_pop,
   rahfp_rsp_if.source             rsp_chan
);

   localparam int PW = rahfp_pkg::POS_W;
   localparam int SW = rahfp_pkg::SHIFT_BITS;
   localparam logic [PW-1:0] LAST_HEX_POS = PW'(rahfp_pkg::HEX_DIGITS);
   localparam logic [PW-1:0] LAST_POS     = PW'(rahfp_pkg::FRAME_BYTES - 1);
   localparam logic [PW-1:0] FRAME_LEN    = PW'(rahfp_pkg::FRAME_BYTES);

   // frame state
   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   last_ff, last_in;
   logic          hex_bad_ff, hex_bad_in;
   logic [SW-1:0] digits_ff, digits_in;

   // response register
   logic                  valid_ff;
   rahfp_pkg::event_type  ev_ff, ev_in;
   rahfp_pkg::error_type  err_ff, err_in;
   logic [7:0]            ver_ff, ver_in;
   logic [31:0]           id_ff, id_in;
   logic [7:0]            sum_ff, sum_in;

   logic [31:0] gap;
   logic        stale;
   logic [7:0]  calc;

   assign q_pop = q_valid && (!valid_ff || rsp_chan.ready);
   assign gap   = q_item.now_ms - last_ff;
   assign stale = (pos_ff != '0) && (gap > {16'd0, timeout_ms});
   assign calc  = digits_ff[SW-1 -: 8] ^ digits_ff[SW-9 -: 8] ^ digits_ff[SW-17 -: 8]
                ^ digits_ff[SW-25 -: 8] ^ digits_ff[SW-33 -: 8];

   always_comb begin
      pos_in     = pos_ff;
      last_in    = last_ff;
      hex_bad_in = hex_bad_ff;
      digits_in  = digits_ff;
      ev_in      = rahfp_pkg::EV_NONE;
      err_in     = rahfp_pkg::ERR_NONE;
      ver_in     = 8'd0;
      id_in      = 32'd0;
      sum_in     = 8'd0;
      priority if (stale) begin
         pos_in  = '0;
         last_in = 32'd0;
         ev_in   = rahfp_pkg::EV_ERROR;
         err_in  = rahfp_pkg::ERR_TIMEOUT;
         if (!q_item.func && q_item.is_start) begin
            pos_in     = PW'(1);
            last_in    = q_item.now_ms;
            hex_bad_in = 1'b0;
         end
      end else if (q_item.func) begin
         // tick with nothing stale
      end else if (q_item.is_start) begin
         pos_in     = PW'(1);
         last_in    = q_item.now_ms;
         hex_bad_in = 1'b0;
      end else if (pos_ff == '0 || pos_ff >= FRAME_LEN) begin
         pos_in = '0;
      end else begin
         pos_in  = pos_ff + PW'(1);
         last_in = q_item.now_ms;
         if (pos_ff <= LAST_HEX_POS) begin
            digits_in  = {digits_ff[SW-5:0], q_item.nibble};
            hex_bad_in = hex_bad_ff || !q_item.hex_ok;
         end
         if (pos_ff == LAST_POS) begin
            pos_in  = '0;
            last_in = 32'd0;
            priority if (!q_item.is_end) begin
               ev_in  = rahfp_pkg::EV_ERROR;
               err_in = rahfp_pkg::ERR_BAD_END;
            end else if (hex_bad_ff) begin
               ev_in  = rahfp_pkg::EV_ERROR;
               err_in = rahfp_pkg::ERR_BAD_HEX;
            end else if (calc != digits_ff[7:0]) begin
               ev_in  = rahfp_pkg::EV_ERROR;
               err_in = rahfp_pkg::ERR_BAD_CHECKSUM;
            end else begin
               ev_in  = rahfp_pkg::EV_TAG;
               ver_in = digits_ff[SW-1 -: 8];
               id_in  = digits_ff[SW-9 -: 32];
               sum_in = digits_ff[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         last_ff  <= 32'd0;
         valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            pos_ff  <= pos_in;
            last_ff <= last_in;
         end
         if (q_pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         hex_bad_ff <= hex_bad_in;
         digits_ff  <= digits_in;
         ev_ff      <= ev_in;
         err_ff     <= err_in;
         ver_ff     <= ver_in;
         id_ff      <= id_in;
         sum_ff     <= sum_in;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.event_res    = ev_ff;
   assign rsp_chan.error_code   = err_ff;
   assign rsp_chan.tag_version  = ver_ff;
   assign rsp_chan.tag_id       = id_ff;
   assign rsp_chan.tag_checksum = sum_ff;

endmodule

`default_nettype wire

>>> hdl/rfid_ascii_hex_frame_parser.sv
// top level of the rfid ascii hex frame parser
//
//  channel    dir  handshake        payload
//  req_chan   in   valid / ready    func, data_byte, now_ms
//  rsp_chan   out  valid / ready    event_res, error_code, tag_version, tag_id, tag_checksum
//  csr_*      in   csr_we           csr_index, csr_wdata
//
// one request per cycle sustained while rsp_chan is ready; every request gives one response,
// registered first in the queue and then in the response register
// the back stage sets throughput, updating the frame state once per cycle unless stalled
// reset is synchronous and clears all control state, no clearing pass
// a stalled response holds in its register while the queue absorbs up to
// QUEUE_DEPTH more requests before req_chan.ready drops
`default_nettype none

module rfid_ascii_hex_frame_parser #(
   parameter int QUEUE_DEPTH = rahfp_pkg::QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rahfp_req_if.sink                               req_chan,
   rahfp_rsp_if.source                             rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [rahfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rahfp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // configuration registers
   logic [15:0] timeout_ff;
   logic [7:0]  start_code_ff;
   logic [7:0]  end_code_ff;

   // front to queue
   logic               q_push;
   logic               q_full;
   rahfp_pkg::cls_type q_push_item;

   // queue to back
   logic               q_valid;
   logic               q_pop;
   rahfp_pkg::cls_type q_head;
   logic [CW-1:0]      q_count;

   // register writes; unused index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= rahfp_pkg::TIMEOUT_RESET;
         start_code_ff <= rahfp_pkg::START_CODE_RESET;
         end_code_ff   <= rahfp_pkg::END_CODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rahfp_pkg::CSR_TIMEOUT:    timeout_ff    <= csr_wdata[15:0];
            rahfp_pkg::CSR_START_CODE: start_code_ff <= csr_wdata[7:0];
            rahfp_pkg::CSR_END_CODE:   end_code_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // classify incoming bytes (hex digit decode, start and end code match)
   rahfp_front u_front (
      .req_chan   (req_chan),
      .start_code (start_code_ff),
      .end_code   (end_code_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   // decouples acceptance from frame processing
   rahfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_item  (q_head),
      .count      (q_count)
   );

   // frame state, timeout, end / hex / xor checks and response register
   rahfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .timeout_ms (timeout_ff),
      .q_valid    (q_valid),
      .q_item     (q_head),
      .q_pop      (q_pop),
      .rsp_chan   (rsp_chan)
   );

   // an accepted request is queued on the next cycle
   a_accept_queued : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (q_count != '0))
      else $error("accepted request not found in queue");

   // a stalled response blocks the back stage
   a_stall_holds_back : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !q_pop)
      else $error("back stage advanced while response stalled");

   // non-error responses carry no error code
   a_code_matches_event : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.event_res != rahfp_pkg::EV_ERROR)
         |-> (rsp_chan.error_code == rahfp_pkg::ERR_NONE))
      else $error("error code on non-error response");

   // tag fields are zero unless a tag is reported
   a_tag_fields_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.event_res != rahfp_pkg::EV_TAG)
         |-> (rsp_chan.tag_version == 8'd0 && rsp_chan.tag_id == 32'd0
              && rsp_chan.tag_checksum == 8'd0))
      else $error("tag fields set without a tag");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the rfid ascii hex frame parser
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rahfp_pkg::*;

   // request kinds on the func field
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // index past the last register, writes to it must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   // ascii bounds of the hex digit ranges
   localparam logic [7:0] ASCII_0  = 8'h30;
   localparam logic [7:0] ASCII_9  = 8'h39;
   localparam logic [7:0] ASCII_UA = 8'h41;
   localparam logic [7:0] ASCII_UF = 8'h46;
   localparam logic [7:0] ASCII_LA = 8'h61;
   localparam logic [7:0] ASCII_LF = 8'h66;

   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 205;
   localparam int LONG_STALL     = 60;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic        func;
      logic [7:0]  data_byte;
      logic [31:0] now_ms;
   } request_t;

   typedef struct packed {
      event_type   event_res;
      error_type   error_code;
      logic [7:0]  tag_version;
      logic [31:0] tag_id;
      logic [7:0]  tag_checksum;
   } tag_result_t;

   // shapes of generated frame traffic
   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_END,
      FRAME_BAD_HEX,
      FRAME_BAD_SUM,
      FRAME_RESTART
   } frame_shape_t;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rahfp_req_if req_bus ();
   rahfp_rsp_if rsp_bus ();

   rfid_ascii_hex_frame_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // requests waiting for the driver, front one is on the bus
   request_t    pending_requests [$];
   // decoded results still owed by the block, oldest first
   tag_result_t expected_results [$];

   // predictor copy of the registers and of the frame state
   logic [15:0] cfg_timeout;
   logic [7:0]  cfg_start;
   logic [7:0]  cfg_end;
   logic [3:0]  frame_pos;
   logic [31:0] last_byte_ms;
   logic [7:0]  frame_bytes [FRAME_BYTES];

   logic        req_fire = 1'b0;
   int          send_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          long_stall_requests = 0;
   int          long_stall_served = 0;
   int          stall_left = 0;
   int          quiet_cycles = 0;

   logic [31:0] stim_now;
   int          requests_queued = 0;
   int          requests_done = 0;
   int          settings_used = 0;
   int          tags_decoded = 0;
   int          error_tally [5];
   int          failures = 0;

   // ascii hex digit decode, bit 4 flags a valid digit
   function automatic logic [4:0] hex_digit_value(logic [7:0] c);
      if (c >= ASCII_0 && c <= ASCII_9) return {1'b1, 4'(c - ASCII_0)};
      if (c >= ASCII_UA && c <= ASCII_UF) return {1'b1, 4'(c - ASCII_UA + 8'd10)};
      if (c >= ASCII_LA && c <= ASCII_LF) return {1'b1, 4'(c - ASCII_LA + 8'd10)};
      return 5'd0;
   endfunction

   // advance the frame state by one request and return what the block must report
   function automatic tag_result_t parse_request(request_t r);
      tag_result_t res;
      logic [4:0]  dv;
      logic [3:0]  nib [HEX_DIGITS];
      logic [7:0]  pay [5];
      logic [7:0]  sum;
      logic [7:0]  calc;
      logic        hex_bad;
      int          i;
      res = '{EV_NONE, ERR_NONE, 8'd0, 32'd0, 8'd0};
      // a partial frame gone stale is dropped first, whatever the request is
      if (frame_pos != 0 && (r.now_ms - last_byte_ms) > {16'd0, cfg_timeout}) begin
         frame_pos = 0;
         last_byte_ms = 0;
         if (r.func == FUNC_BYTE && r.data_byte == cfg_start) begin
            frame_bytes[0] = r.data_byte;
            frame_pos = 1;
            last_byte_ms = r.now_ms;
         end
         res.event_res = EV_ERROR;
         res.error_code = ERR_TIMEOUT;
         return res;
      end
      if (r.func == FUNC_TICK) return res;
      // the start code reopens the frame at any position
      if (r.data_byte == cfg_start) begin
         frame_bytes[0] = r.data_byte;
         frame_pos = 1;
         last_byte_ms = r.now_ms;
         return res;
      end
      if (frame_pos == 0 || frame_pos >= FRAME_BYTES) begin
         frame_pos = 0;
         return res;
      end
      frame_bytes[frame_pos] = r.data_byte;
      frame_pos++;
      last_byte_ms = r.now_ms;
      if (frame_pos != FRAME_BYTES) return res;
      // frame complete: end code, then digits, then xor, first failure wins
      frame_pos = 0;
      last_byte_ms = 0;
      res.event_res = EV_ERROR;
      if (frame_bytes[FRAME_BYTES-1] != cfg_end) begin
         res.error_code = ERR_BAD_END;
         return res;
      end
      hex_bad = 1'b0;
      for (i = 0; i < HEX_DIGITS; i++) begin
         dv = hex_digit_value(frame_bytes[i+1]);
         hex_bad |= ~dv[4];
         nib[i] = dv[3:0];
      end
      if (hex_bad) begin
         res.error_code = ERR_BAD_HEX;
         return res;
      end
      calc = 8'd0;
      for (i = 0; i < 5; i++) begin
         pay[i] = {nib[2*i], nib[2*i+1]};
         calc ^= pay[i];
      end
      sum = {nib[10], nib[11]};
      if (calc != sum) begin
         res.error_code = ERR_BAD_CHECKSUM;
         return res;
      end
      res.event_res = EV_TAG;
      res.tag_version = pay[0];
      res.tag_id = {pay[1], pay[2], pay[3], pay[4]};
      res.tag_checksum = sum;
      return res;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   task automatic queue_request(logic func, logic [7:0] b, logic [31:0] t);
      pending_requests.push_back(request_t'{func, b, t});
      requests_queued++;
   endtask

   // random-case hex digit; a letter equal to the start code flips case
   function automatic logic [7:0] hex_char(logic [3:0] n);
      logic [7:0] c;
      if (n < 10) begin
         c = ASCII_0 + 8'(n);
      end else begin
         c = ($urandom_range(0, 1) ? ASCII_LA : ASCII_UA) + 8'(n) - 8'd10;
         if (c == cfg_start) c = c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      logic [4:0] dv;
      do begin
         b = 8'($urandom);
         dv = hex_digit_value(b);
      end while (dv[4] || b == cfg_start);
      return b;
   endfunction

   // gap between bytes that keeps the frame alive, the limit itself now and then
   function automatic logic [31:0] frame_gap();
      if ($urandom_range(0, 7) == 0) return {16'd0, cfg_timeout};
      return 32'($urandom_range(0, (cfg_timeout < 40) ? cfg_timeout : 40));
   endfunction

   // gap that expires the frame, often by exactly one ms
   function automatic logic [31:0] stale_gap();
      return {16'd0, cfg_timeout} + 32'd1 +
             ($urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 5000)));
   endfunction

   // one full frame of random payload, optionally broken in one way
   task automatic queue_frame(frame_shape_t shape);
      logic [7:0] pay [5];
      logic [7:0] digits [HEX_DIGITS];
      logic [7:0] chk;
      logic [7:0] end_byte;
      int         i;
      int         prefix;
      chk = 8'd0;
      for (i = 0; i < 5; i++) begin
         pay[i] = 8'($urandom);
         chk ^= pay[i];
      end
      if (shape == FRAME_BAD_SUM) chk ^= 8'($urandom_range(1, 255));
      for (i = 0; i < 5; i++) begin
         digits[2*i]   = hex_char(pay[i][7:4]);
         digits[2*i+1] = hex_char(pay[i][3:0]);
      end
      digits[10] = hex_char(chk[7:4]);
      digits[11] = hex_char(chk[3:0]);
      if (shape == FRAME_BAD_HEX)
         digits[$urandom_range(0, HEX_DIGITS-1)] = non_hex_byte();
      end_byte = cfg_end;
      if (shape == FRAME_BAD_END) begin
         do end_byte = 8'($urandom); while (end_byte == cfg_end || end_byte == cfg_start);
         // sometimes a bad digit as well, the end code check must still win
         if ($urandom_range(0, 1)) digits[$urandom_range(0, HEX_DIGITS-1)] = non_hex_byte();
      end
      // aborted partial frame that the following start code throws away
      if (shape == FRAME_RESTART) begin
         stim_now += frame_gap();
         queue_request(FUNC_BYTE, cfg_start, stim_now);
         prefix = $urandom_range(1, HEX_DIGITS - 1);
         for (i = 0; i < prefix; i++) begin
            stim_now += frame_gap();
            queue_request(FUNC_BYTE, hex_char(4'($urandom)), stim_now);
         end
      end
      stim_now += frame_gap();
      queue_request(FUNC_BYTE, cfg_start, stim_now);
      for (i = 0; i < HEX_DIGITS; i++) begin
         // a tick inside the frame must not disturb it
         if ($urandom_range(0, 11) == 0)
            queue_request(FUNC_TICK, 8'($urandom), stim_now + frame_gap());
         stim_now += frame_gap();
         queue_request(FUNC_BYTE, digits[i], stim_now);
      end
      stim_now += frame_gap();
      queue_request(FUNC_BYTE, end_byte, stim_now);
   endtask

   // partial frame that goes stale, closed by a late tick or byte
   task automatic queue_timeout();
      int i;
      int digits;
      stim_now += frame_gap();
      queue_request(FUNC_BYTE, cfg_start, stim_now);
      digits = $urandom_range(0, HEX_DIGITS);
      for (i = 0; i < digits; i++) begin
         stim_now += frame_gap();
         queue_request(FUNC_BYTE, hex_char(4'($urandom)), stim_now);
      end
      stim_now += stale_gap();
      if ($urandom_range(0, 2) == 0)
         queue_request(FUNC_TICK, 8'($urandom), stim_now);
      else
         queue_request(FUNC_BYTE, $urandom_range(0, 1) ? cfg_start : 8'($urandom), stim_now);
   endtask

   // mostly well-formed frames, the rest errors, ticks and line noise
   task automatic queue_random_traffic(int count);
      int target;
      int pick;
      target = requests_queued + count;
      while (requests_queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) queue_frame(FRAME_GOOD);
         else if (pick < 48) queue_frame(FRAME_BAD_END);
         else if (pick < 56) queue_frame(FRAME_BAD_HEX);
         else if (pick < 64) queue_frame(FRAME_BAD_SUM);
         else if (pick < 72) queue_frame(FRAME_RESTART);
         else if (pick < 82) queue_timeout();
         else if (pick < 91) begin
            stim_now += 32'($urandom_range(0, 300));
            queue_request(FUNC_TICK, 8'($urandom), stim_now);
         end else begin
            // noise byte, sometimes with a wild jump in time
            if ($urandom_range(0, 3) == 0) stim_now = $urandom;
            else stim_now += 32'($urandom_range(0, 300));
            queue_request(FUNC_BYTE, 8'($urandom), stim_now);
         end
      end
   endtask

   // all requests sent and every response back, then let the pipe settle
   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // request driver: holds an offered request until it is taken
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      logic offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_fire) void'(pending_requests.pop_front());
         if (req_bus.valid && !req_fire)
            offer = 1'b1;
         else
            offer = pending_requests.size() != 0 &&
                    !(send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct);
         req_bus.valid <= offer;
         if (offer) begin
            req_bus.func      <= pending_requests[0].func;
            req_bus.data_byte <= pending_requests[0].data_byte;
            req_bus.now_ms    <= pending_requests[0].now_ms;
         end
      end
   end

   // ---------------------------------------------------------------
   // response receiver: random back pressure plus long hold-offs on demand
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (long_stall_served != long_stall_requests) begin
         long_stall_served++;
         stall_left = LONG_STALL - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !(rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // monitor: predicts on every accepted request, checks every response
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      request_t    seen;
      tag_result_t want;
      if (reset) begin
         cfg_timeout  = TIMEOUT_RESET;
         cfg_start    = START_CODE_RESET;
         cfg_end      = END_CODE_RESET;
         frame_pos    = '0;
         last_byte_ms = '0;
         req_fire    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT:    cfg_timeout = csr_wdata;
               CSR_START_CODE: cfg_start = csr_wdata[7:0];
               CSR_END_CODE:   cfg_end = csr_wdata[7:0];
               default: ;
            endcase
         end
         req_fire <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            seen = '{req_bus.func, req_bus.data_byte, req_bus.now_ms};
            expected_results.push_back(parse_request(seen));
            requests_done++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               failures++;
               $display("%0t: response with none expected, event %0h error %0h",
                        $time, rsp_bus.event_res, rsp_bus.error_code);
            end else begin
               want = expected_results.pop_front();
               check_field("event_res", want.event_res, rsp_bus.event_res);
               check_field("error_code", want.error_code, rsp_bus.error_code);
               check_field("tag_version", want.tag_version, rsp_bus.tag_version);
               check_field("tag_id", want.tag_id, rsp_bus.tag_id);
               check_field("tag_checksum", want.tag_checksum, rsp_bus.tag_checksum);
               if (want.event_res == EV_TAG) tags_decoded++;
               if (want.event_res == EV_ERROR) error_tally[want.error_code]++;
            end
         end
      end
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                  $time, WATCHDOG_LIMIT, expected_results.size());
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      string            hex_text;
      int               i;
      int               phase;
      logic [15:0]      tmo;
      logic [7:0]       sc;
      logic [7:0]       ec;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_BYTE;
      req_bus.data_byte = 8'd0;
      req_bus.now_ms    = 32'd0;
      rsp_bus.ready     = 1'b0;
      for (i = 0; i < 5; i++) error_tally[i] = 0;
      send_idle_pct = 10;
      rsp_idle_pct  = 64;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the spare register index has no effect
      write_register(CSR_SPARE_INDEX, 16'hFFFF);

      // directed part at reset settings
      // noise while idle and a tick with nothing open
      queue_request(FUNC_BYTE, 8'hFF, 32'hFFFF_FFFF);
      queue_request(FUNC_TICK, 8'h00, 32'h0000_0000);
      // good frame, mixed case digits, payload xor is 1e
      hex_text = "1A2b3C4d5E1e";
      queue_request(FUNC_BYTE, START_CODE_RESET, 32'd1000);
      for (i = 0; i < HEX_DIGITS; i++)
         queue_request(FUNC_BYTE, hex_text[i], 32'd1001 + 32'(i));
      queue_request(FUNC_BYTE, END_CODE_RESET, 32'd1013);
      // tick right at the limit survives, one ms later it times out
      queue_request(FUNC_BYTE, START_CODE_RESET, 32'd2000);
      queue_request(FUNC_TICK, 8'hA5, 32'd2100);
      queue_request(FUNC_TICK, 8'h5A, 32'd2101);
      // gap across the wrap of the ms counter, then a late start code
      // that both times out and opens the next frame
      queue_request(FUNC_BYTE, START_CODE_RESET, 32'hFFFF_FFF0);
      queue_request(FUNC_BYTE, ASCII_0, 32'h0000_0053);
      queue_request(FUNC_BYTE, START_CODE_RESET, 32'h0000_00B8);
      queue_request(FUNC_BYTE, 8'h00, 32'h0000_011C);
      wait_drained();

      // random phases, each with its own register settings and idle pattern
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0, 1: begin send_idle_pct = 10; rsp_idle_pct = 64; end
            2, 3: begin send_idle_pct = 64; rsp_idle_pct = 10; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         case (phase)
            0: begin tmo = TIMEOUT_RESET; sc = START_CODE_RESET; ec = END_CODE_RESET; end
            1: begin tmo = 16'd0; sc = 8'h00; ec = 8'hFF; end
            2: begin tmo = 16'hFFFF; sc = 8'hFF; ec = 8'h00; end
            3: begin
               tmo = 16'($urandom_range(2, 3000));
               sc = 8'($urandom);
               do ec = 8'($urandom); while (ec == sc);
            end
            4: begin tmo = 16'd1; sc = 8'h3A; ec = 8'h0D; end
            default: begin tmo = 16'd50; sc = ASCII_LA; ec = 8'h0A; end
         endcase
         // junk in the upper byte of the eight bit registers is dropped
         write_register(CSR_TIMEOUT, tmo);
         write_register(CSR_START_CODE, {8'($urandom), sc});
         write_register(CSR_END_CODE, {8'($urandom), ec});
         settings_used++;
         // long receiver hold-off while the sender keeps offering
         if (phase == 1 || phase == 4) long_stall_requests++;
         // the wide timeout phase runs across the wrap of the ms counter
         stim_now = (phase == 2) ? 32'hFFFF_0000 : $urandom;
         queue_random_traffic(PHASE_ITEMS);
         wait_drained();
      end

      repeat (6) @(posedge clock);
      $display("covered %0d requests under %0d register settings, with idle gaps and back pressure",
               requests_done, settings_used);
      $display("%0d tags decoded; errors: timeout %0d, bad end %0d, bad hex %0d, bad checksum %0d",
               tags_decoded, error_tally[ERR_TIMEOUT], error_tally[ERR_BAD_END],
               error_tally[ERR_BAD_HEX], error_tally[ERR_BAD_CHECKSUM]);
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

>>> rfid_ascii_hex_frame_parser.f
hdl/rahfp_pkg.sv
hdl/rahfp_if.sv
hdl/rahfp_front.sv
hdl/rahfp_queue.sv
hdl/rahfp_back.sv
hdl/rfid_ascii_hex_frame_parser.sv
verif/testbench.sv
